@@ hdl/mcmd_pkg.sv @@
// Shared types and constants for the MIDI channel message decoder.
// No dependencies; every other file takes names from here by scope.
package mcmd_pkg;

  localparam int CHANNELS   = 16;
  localparam int CHAN_W     = 4;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DATA_W     = 7;
  localparam int RPN_W      = 8;

  localparam logic [CHAN_W:0]  CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);
  localparam logic [RPN_W-1:0] RPN_NONE   = 8'hFF;
  localparam logic [RPN_W-1:0] RPN_ZERO   = 8'h00;
  localparam logic [RPN_W-1:0] RPN_NULL_7 = 8'h7F;

  // status byte upper nibble
  typedef enum logic [3:0] {
    ST_NOTEOFF  = 4'h8,
    ST_NOTEON   = 4'h9,
    ST_PRESSURE = 4'hA,
    ST_CONTROL  = 4'hB,
    ST_PROGRAM  = 4'hC,
    ST_PITCH    = 4'hE
  } status_type_t;

  // controller numbers
  typedef enum logic [DATA_W-1:0] {
    CC_BANK       = 7'h00,
    CC_DATA_ENTRY = 7'h06,
    CC_VOLUME     = 7'h07,
    CC_PAN        = 7'h0A,
    CC_EXPRESSION = 7'h0B,
    CC_SUSTAIN    = 7'h40,
    CC_NRPN_LSB   = 7'h62,
    CC_NRPN_MSB   = 7'h63,
    CC_RPN_LSB    = 7'h64,
    CC_RPN_MSB    = 7'h65,
    CC_SOUNDSOFF  = 7'h78,
    CC_RESETCTL   = 7'h79,
    CC_NOTESOFF   = 7'h7B,
    CC_MONO       = 7'h7E,
    CC_POLY       = 7'h7F
  } ctl_num_t;

  typedef enum logic [3:0] {
    EV_NOTEOFF    = 4'd0,
    EV_NOTEON     = 4'd1,
    EV_PRESSURE   = 4'd2,
    EV_PITCHRANGE = 4'd3,
    EV_PITCHWHEEL = 4'd4,
    EV_VOLUME     = 4'd5,
    EV_PAN        = 4'd6,
    EV_EXPRESSION = 4'd7,
    EV_PROGRAM    = 4'd8,
    EV_SUSTAIN    = 4'd9,
    EV_RESETCTL   = 4'd10,
    EV_NOTESOFF   = 4'd11,
    EV_SOUNDSOFF  = 4'd12,
    EV_MONO       = 4'd13,
    EV_POLY       = 4'd14,
    EV_BANK       = 4'd15
  } ev_kind_t;

  localparam logic [DATA_W-1:0] RANGE_DEFAULT = 7'd2;

endpackage

@@ hdl/mcmd_if.sv @@
// Valid/ready channel interfaces for message words in and event words out.
// Depends on mcmd_pkg for field widths.
interface mcmd_msg_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   status_byte;
  logic [mcmd_pkg::DATA_W-1:0]  data1;
  logic [mcmd_pkg::DATA_W-1:0]  data2;

  modport source (output valid, output status_byte, output data1, output data2,
                  input ready);
  modport sink   (input valid, input status_byte, input data1, input data2,
                  output ready);
endinterface

interface mcmd_evt_if;
  logic                         valid;
  logic                         ready;
  logic [3:0]                   event_kind;
  logic [mcmd_pkg::CHAN_W-1:0]  channel_out;
  logic [mcmd_pkg::DATA_W-1:0]  key_field;
  logic [mcmd_pkg::DATA_W-1:0]  value_field;

  modport source (output valid, output event_kind, output channel_out,
                  output key_field, output value_field, input ready);
  modport sink   (input valid, input event_kind, input channel_out,
                  input key_field, input value_field, output ready);
endinterface

@@ hdl/midi_channel_message_decoder.sv @@
// MIDI channel voice message decoder with per-channel RPN registers.
// Input register feeds the result register; one word per cycle unless the output stalls.
// The per-channel RPN flops are read and written in the decode stage, so back-to-back
// messages on one channel see each other's updates. Sync active-low reset clears the
// pipeline valids and sets every RPN register to 0xFF (nothing selected).
// Depends on mcmd_pkg and the channel interfaces in mcmd_if.sv.
module midi_channel_message_decoder (
  input  logic               clk,
  input  logic               rst_n,
  mcmd_msg_if.sink           in_msg,
  mcmd_evt_if.source         out_evt
);

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic                             s1_valid_r;
  logic [7:0]                       s1_status_r;
  logic [mcmd_pkg::DATA_W-1:0]      s1_d1_r;
  logic [mcmd_pkg::DATA_W-1:0]      s1_d2_r;

  // per-channel RPN pair
  logic [mcmd_pkg::RPN_W-1:0]       rpn_high_r [mcmd_pkg::CHANNELS];
  logic [mcmd_pkg::RPN_W-1:0]       rpn_low_r  [mcmd_pkg::CHANNELS];

  // result register
  logic                             out_valid_r;
  mcmd_pkg::ev_kind_t               out_kind_r;
  logic [mcmd_pkg::CHAN_W-1:0]      out_chan_r;
  logic [mcmd_pkg::DATA_W-1:0]      out_key_r;
  logic [mcmd_pkg::DATA_W-1:0]      out_val_r;

  // decode outputs
  logic                             has_ev;
  mcmd_pkg::ev_kind_t               ev_kind;
  logic [mcmd_pkg::DATA_W-1:0]      ev_key;
  logic [mcmd_pkg::DATA_W-1:0]      ev_val;
  logic                             hi_we;
  logic                             lo_we;
  logic [mcmd_pkg::RPN_W-1:0]       hi_d;
  logic [mcmd_pkg::RPN_W-1:0]       lo_d;

  logic [3:0]                       s1_type;
  logic [mcmd_pkg::CHAN_W-1:0]      s1_chan;
  logic [mcmd_pkg::CHAN_IDX_W-1:0]  s1_idx;
  logic                             chan_ok;
  logic [mcmd_pkg::RPN_W-1:0]       cur_hi;
  logic [mcmd_pkg::RPN_W-1:0]       cur_lo;

  logic                             out_free;
  logic                             s1_go;
  logic                             in_fire;

  assign s1_type = s1_status_r[7:4];
  assign s1_chan = s1_status_r[mcmd_pkg::CHAN_W-1:0];
  assign s1_idx  = s1_chan[mcmd_pkg::CHAN_IDX_W-1:0];
  assign chan_ok = {1'b0, s1_chan} < mcmd_pkg::CHAN_LIMIT;
  assign cur_hi  = rpn_high_r[s1_idx];
  assign cur_lo  = rpn_low_r[s1_idx];

  // Output slot is free when empty or being drained this cycle. Words with no
  // event retire regardless of the output side.
  assign out_free     = !out_valid_r || out_evt.ready;
  assign s1_go        = s1_valid_r && (!has_ev || out_free);
  assign in_msg.ready = !s1_valid_r || s1_go;
  assign in_fire      = in_msg.valid && in_msg.ready;

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  always_comb begin
    has_ev  = 1'b0;
    ev_kind = mcmd_pkg::EV_NOTEOFF;
    ev_key  = s1_d1_r;
    ev_val  = '0;
    hi_we   = 1'b0;
    lo_we   = 1'b0;
    hi_d    = mcmd_pkg::RPN_NONE;
    lo_d    = mcmd_pkg::RPN_NONE;
    if (chan_ok) begin
      unique case (s1_type)
        mcmd_pkg::ST_NOTEOFF: begin
          has_ev  = 1'b1;
          ev_kind = mcmd_pkg::EV_NOTEOFF;
        end
        mcmd_pkg::ST_NOTEON: begin
          has_ev  = 1'b1;
          ev_kind = mcmd_pkg::EV_NOTEON;
          ev_val  = s1_d2_r;
        end
        mcmd_pkg::ST_PRESSURE: begin
          has_ev  = 1'b1;
          ev_kind = mcmd_pkg::EV_PRESSURE;
          ev_val  = s1_d2_r;
        end
        mcmd_pkg::ST_PROGRAM: begin
          has_ev  = 1'b1;
          ev_kind = mcmd_pkg::EV_PROGRAM;
        end
        mcmd_pkg::ST_PITCH: begin
          has_ev  = 1'b1;
          ev_kind = mcmd_pkg::EV_PITCHWHEEL;
          ev_val  = s1_d2_r;
        end
        mcmd_pkg::ST_CONTROL: begin
          // controller value goes out in the key field
          ev_key = s1_d2_r;
          unique case (s1_d1_r)
            mcmd_pkg::CC_BANK:       begin has_ev = 1'b1; ev_kind = mcmd_pkg::EV_BANK;       end
            mcmd_pkg::CC_VOLUME:     begin has_ev = 1'b1; ev_kind = mcmd_pkg::EV_VOLUME;     end
            mcmd_pkg::CC_PAN:        begin has_ev = 1'b1; ev_kind = mcmd_pkg::EV_PAN;        end
            mcmd_pkg::CC_EXPRESSION: begin has_ev = 1'b1; ev_kind = mcmd_pkg::EV_EXPRESSION; end
            mcmd_pkg::CC_SUSTAIN:    begin has_ev = 1'b1; ev_kind = mcmd_pkg::EV_SUSTAIN;    end
            mcmd_pkg::CC_SOUNDSOFF: begin
              has_ev = 1'b1; ev_kind = mcmd_pkg::EV_SOUNDSOFF; ev_key = '0;
            end
            mcmd_pkg::CC_RESETCTL: begin
              has_ev = 1'b1; ev_kind = mcmd_pkg::EV_RESETCTL; ev_key = '0;
            end
            mcmd_pkg::CC_NOTESOFF: begin
              has_ev = 1'b1; ev_kind = mcmd_pkg::EV_NOTESOFF; ev_key = '0;
            end
            mcmd_pkg::CC_MONO: begin
              has_ev = 1'b1; ev_kind = mcmd_pkg::EV_MONO; ev_key = '0;
            end
            mcmd_pkg::CC_POLY: begin
              has_ev = 1'b1; ev_kind = mcmd_pkg::EV_POLY; ev_key = '0;
            end
            mcmd_pkg::CC_NRPN_LSB: lo_we = 1'b1;
            mcmd_pkg::CC_NRPN_MSB: hi_we = 1'b1;
            mcmd_pkg::CC_RPN_LSB: begin
              hi_we = 1'b1;
              hi_d  = {1'b0, s1_d2_r};
            end
            mcmd_pkg::CC_RPN_MSB: begin
              lo_we = 1'b1;
              lo_d  = {1'b0, s1_d2_r};
            end
            mcmd_pkg::CC_DATA_ENTRY: begin
              ev_kind = mcmd_pkg::EV_PITCHRANGE;
              if (cur_hi == mcmd_pkg::RPN_ZERO && cur_lo == mcmd_pkg::RPN_ZERO) begin
                has_ev = 1'b1;
              end else if (cur_hi == mcmd_pkg::RPN_NULL_7 &&
                           cur_lo == mcmd_pkg::RPN_NULL_7) begin
                // null-ish pair: default range, then deselect
                has_ev = 1'b1;
                ev_key = mcmd_pkg::RANGE_DEFAULT;
                hi_we  = 1'b1;
                lo_we  = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= in_msg.status_byte;
      s1_d1_r     <= in_msg.data1;
      s1_d2_r     <= in_msg.data2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcmd_pkg::CHANNELS; i++) begin
        rpn_high_r[i] <= mcmd_pkg::RPN_NONE;
        rpn_low_r[i]  <= mcmd_pkg::RPN_NONE;
      end
    end else if (s1_go) begin
      if (hi_we) begin
        rpn_high_r[s1_idx] <= hi_d;
      end
      if (lo_we) begin
        rpn_low_r[s1_idx] <= lo_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && has_ev) begin
      out_valid_r <= 1'b1;
    end else if (out_evt.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_ev) begin
      out_kind_r <= ev_kind;
      out_chan_r <= s1_chan;
      out_key_r  <= ev_key;
      out_val_r  <= ev_val;
    end
  end

  assign out_evt.valid       = out_valid_r;
  assign out_evt.event_kind  = out_kind_r;
  assign out_evt.channel_out = out_chan_r;
  assign out_evt.key_field   = out_key_r;
  assign out_evt.value_field = out_val_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && has_ev) |-> (!out_valid_r || out_evt.ready))
    else $error("result register overwritten while held");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |-> !in_msg.ready)
    else $error("input accepted over a stalled word");

  a_null_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && has_ev && hi_we && lo_we) |=>
      (rpn_high_r[$past(s1_idx)] == mcmd_pkg::RPN_NONE &&
       rpn_low_r[$past(s1_idx)] == mcmd_pkg::RPN_NONE))
    else $error("RPN pair not cleared after default range");

endmodule

@@ bench/midi_channel_message_decoder_test.sv @@
// Self-checking bench for midi_channel_message_decoder: a directed table, then random traffic.
// Each accepted word is run through a local decoder with its own RPN registers.
// Depends on mcmd_pkg and the mcmd_msg_if / mcmd_evt_if interfaces from the RTL.
module midi_channel_message_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_WORDS  = 620;
  localparam int SETTLE_CYCLES = 6;    // pipeline is two stages deep
  localparam int STALL_LIMIT   = 600;  // several times the longest receiver hold-off
  localparam int MAX_REPORTS   = 40;
  localparam int N_DIRECTED    = 27;

  // One decoded synth event, laid out as the event word fields.
  typedef struct packed {
    mcmd_pkg::ev_kind_t kind;
    logic [3:0]         chan;
    logic [6:0]         key;
    logic [6:0]         val;
  } synth_event_t;

  // Directed row: the message, plus a hand-written expectation where one is obvious.
  typedef struct {
    logic [7:0]   st;
    logic [6:0]   d1;
    logic [6:0]   d2;
    bit           known;
    bit           fires;
    synth_event_t ev;
  } msg_row_t;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  mcmd_msg_if msg_if();
  mcmd_evt_if evt_if();

  midi_channel_message_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_msg  (msg_if),
    .out_evt (evt_if)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Local copy of the per-channel parameter select registers.
  logic [mcmd_pkg::RPN_W-1:0] sel_param_hi [mcmd_pkg::CHANNELS];
  logic [mcmd_pkg::RPN_W-1:0] sel_param_lo [mcmd_pkg::CHANNELS];

  synth_event_t pending_events [$];

  int errors;
  int words_sent;
  int live_words;      // words with a status type the block decodes
  int events_checked;
  int range_events;
  int holdoffs;
  int burst_left;
  int stall_cycles;
  bit [15:0] kinds_seen;

  logic [3:0] msg_types [6] = '{mcmd_pkg::ST_NOTEOFF, mcmd_pkg::ST_NOTEON,
                                mcmd_pkg::ST_PRESSURE, mcmd_pkg::ST_CONTROL,
                                mcmd_pkg::ST_PROGRAM, mcmd_pkg::ST_PITCH};
  logic [6:0] known_ctls [15] = '{mcmd_pkg::CC_BANK, mcmd_pkg::CC_DATA_ENTRY,
                                  mcmd_pkg::CC_VOLUME, mcmd_pkg::CC_PAN,
                                  mcmd_pkg::CC_EXPRESSION, mcmd_pkg::CC_SUSTAIN,
                                  mcmd_pkg::CC_NRPN_LSB, mcmd_pkg::CC_NRPN_MSB,
                                  mcmd_pkg::CC_RPN_LSB, mcmd_pkg::CC_RPN_MSB,
                                  mcmd_pkg::CC_SOUNDSOFF, mcmd_pkg::CC_RESETCTL,
                                  mcmd_pkg::CC_NOTESOFF, mcmd_pkg::CC_MONO,
                                  mcmd_pkg::CC_POLY};

  // Directed table. Typed expectations cover reset state, extremes and the
  // no-event cases; the rest are left to the decoder model.
  msg_row_t directed_rows [N_DIRECTED] = '{
    // message types at field extremes
    '{8'h80, 7'd0,   7'd0,   1, 1, '{mcmd_pkg::EV_NOTEOFF,    4'd0,  7'd0,   7'd0}},
    '{8'h9F, 7'd127, 7'd127, 1, 1, '{mcmd_pkg::EV_NOTEON,     4'd15, 7'd127, 7'd127}},
    // note on with zero velocity stays a note on
    '{8'h93, 7'd60,  7'd0,   1, 1, '{mcmd_pkg::EV_NOTEON,     4'd3,  7'd60,  7'd0}},
    '{8'hA5, 7'd127, 7'd1,   0, 0, '0},
    '{8'hCF, 7'd127, 7'd55,  1, 1, '{mcmd_pkg::EV_PROGRAM,    4'd15, 7'd127, 7'd0}},
    '{8'hE0, 7'd127, 7'd127, 1, 1, '{mcmd_pkg::EV_PITCHWHEEL, 4'd0,  7'd127, 7'd127}},
    // every event-producing controller
    '{8'hB0, mcmd_pkg::CC_BANK,       7'd127, 1, 1,
      '{mcmd_pkg::EV_BANK,      4'd0,  7'd127, 7'd0}},
    '{8'hB1, mcmd_pkg::CC_VOLUME,     7'd100, 0, 0, '0},
    '{8'hB2, mcmd_pkg::CC_PAN,        7'd64,  0, 0, '0},
    '{8'hB3, mcmd_pkg::CC_EXPRESSION, 7'd0,   0, 0, '0},
    '{8'hB4, mcmd_pkg::CC_SUSTAIN,    7'd127, 0, 0, '0},
    '{8'hB5, mcmd_pkg::CC_SOUNDSOFF,  7'd9,   1, 1,
      '{mcmd_pkg::EV_SOUNDSOFF, 4'd5,  7'd0,   7'd0}},
    '{8'hB6, mcmd_pkg::CC_RESETCTL,   7'd127, 0, 0, '0},
    '{8'hB7, mcmd_pkg::CC_NOTESOFF,   7'd0,   0, 0, '0},
    '{8'hB8, mcmd_pkg::CC_MONO,       7'd1,   0, 0, '0},
    '{8'hBF, mcmd_pkg::CC_POLY,       7'd127, 1, 1,
      '{mcmd_pkg::EV_POLY,      4'd15, 7'd0,   7'd0}},
    // unhandled status type and unhandled controller: nothing comes out
    '{8'hD4, 7'd10,  7'd20,  1, 0, '0},
    '{8'hB9, 7'h01,  7'd50,  1, 0, '0},
    // data entry with nothing selected after reset
    '{8'hBA, mcmd_pkg::CC_DATA_ENTRY, 7'd12,  1, 0, '0},
    // select parameter 0000, then data entry gives a pitch range
    '{8'hBA, mcmd_pkg::CC_RPN_LSB,    7'd0,   1, 0, '0},
    '{8'hBA, mcmd_pkg::CC_RPN_MSB,    7'd0,   1, 0, '0},
    '{8'hBA, mcmd_pkg::CC_DATA_ENTRY, 7'd24,  1, 1,
      '{mcmd_pkg::EV_PITCHRANGE, 4'd10, 7'd24, 7'd0}},
    // nulling the low half deselects
    '{8'hBA, mcmd_pkg::CC_NRPN_LSB,   7'd33,  1, 0, '0},
    '{8'hBA, mcmd_pkg::CC_DATA_ENTRY, 7'd5,   1, 0, '0},
    // 7F7F: data entry gives the default range and clears the selection
    '{8'hBC, mcmd_pkg::CC_RPN_LSB,    7'd127, 1, 0, '0},
    '{8'hBC, mcmd_pkg::CC_RPN_MSB,    7'd127, 1, 0, '0},
    '{8'hBC, mcmd_pkg::CC_DATA_ENTRY, 7'd99,  1, 1,
      '{mcmd_pkg::EV_PITCHRANGE, 4'd12, 7'd2, 7'd0}}
  };

  // Decodes one message word, updating the local select registers.
  // Returns 1 when the word produces an event.
  function automatic bit decode_message(input logic [7:0] st, input logic [6:0] d1,
                                        input logic [6:0] d2, output synth_event_t ev);
    logic [3:0] ch;
    ch = st[3:0];
    ev = '0;
    ev.chan = ch;
    if (int'(ch) >= mcmd_pkg::CHANNELS) return 1'b0;
    case (st[7:4])
      mcmd_pkg::ST_NOTEOFF: begin
        ev.kind = mcmd_pkg::EV_NOTEOFF;  ev.key = d1;  return 1'b1;
      end
      mcmd_pkg::ST_NOTEON: begin
        ev.kind = mcmd_pkg::EV_NOTEON;  ev.key = d1;  ev.val = d2;  return 1'b1;
      end
      mcmd_pkg::ST_PRESSURE: begin
        ev.kind = mcmd_pkg::EV_PRESSURE;  ev.key = d1;  ev.val = d2;  return 1'b1;
      end
      mcmd_pkg::ST_PROGRAM: begin
        ev.kind = mcmd_pkg::EV_PROGRAM;  ev.key = d1;  return 1'b1;
      end
      mcmd_pkg::ST_PITCH: begin
        ev.kind = mcmd_pkg::EV_PITCHWHEEL;  ev.key = d1;  ev.val = d2;  return 1'b1;
      end
      mcmd_pkg::ST_CONTROL: begin
        ev.key = d2;
        case (d1)
          mcmd_pkg::CC_BANK:       begin ev.kind = mcmd_pkg::EV_BANK;       return 1'b1; end
          mcmd_pkg::CC_VOLUME:     begin ev.kind = mcmd_pkg::EV_VOLUME;     return 1'b1; end
          mcmd_pkg::CC_PAN:        begin ev.kind = mcmd_pkg::EV_PAN;        return 1'b1; end
          mcmd_pkg::CC_EXPRESSION: begin ev.kind = mcmd_pkg::EV_EXPRESSION; return 1'b1; end
          mcmd_pkg::CC_SUSTAIN:    begin ev.kind = mcmd_pkg::EV_SUSTAIN;    return 1'b1; end
          mcmd_pkg::CC_DATA_ENTRY: begin
            ev.kind = mcmd_pkg::EV_PITCHRANGE;
            if ({sel_param_hi[ch], sel_param_lo[ch]} ==
                {mcmd_pkg::RPN_ZERO, mcmd_pkg::RPN_ZERO}) return 1'b1;
            if ({sel_param_hi[ch], sel_param_lo[ch]} ==
                {mcmd_pkg::RPN_NULL_7, mcmd_pkg::RPN_NULL_7}) begin
              sel_param_hi[ch] = mcmd_pkg::RPN_NONE;
              sel_param_lo[ch] = mcmd_pkg::RPN_NONE;
              ev.key = mcmd_pkg::RANGE_DEFAULT;
              return 1'b1;
            end
            return 1'b0;
          end
          // 0x62/0x63 null one half; 0x64 loads the high half, 0x65 the low half
          mcmd_pkg::CC_NRPN_LSB: begin sel_param_lo[ch] = mcmd_pkg::RPN_NONE; return 1'b0; end
          mcmd_pkg::CC_NRPN_MSB: begin sel_param_hi[ch] = mcmd_pkg::RPN_NONE; return 1'b0; end
          mcmd_pkg::CC_RPN_LSB:  begin sel_param_hi[ch] = {1'b0, d2};         return 1'b0; end
          mcmd_pkg::CC_RPN_MSB:  begin sel_param_lo[ch] = {1'b0, d2};         return 1'b0; end
          mcmd_pkg::CC_SOUNDSOFF: begin
            ev.kind = mcmd_pkg::EV_SOUNDSOFF; ev.key = '0; return 1'b1;
          end
          mcmd_pkg::CC_RESETCTL: begin
            ev.kind = mcmd_pkg::EV_RESETCTL;  ev.key = '0; return 1'b1;
          end
          mcmd_pkg::CC_NOTESOFF: begin
            ev.kind = mcmd_pkg::EV_NOTESOFF;  ev.key = '0; return 1'b1;
          end
          mcmd_pkg::CC_MONO: begin
            ev.kind = mcmd_pkg::EV_MONO;      ev.key = '0; return 1'b1;
          end
          mcmd_pkg::CC_POLY: begin
            ev.kind = mcmd_pkg::EV_POLY;      ev.key = '0; return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  // Data byte biased toward its extremes.
  function automatic logic [6:0] rand7();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Offers one message word in bursts with random gaps. Called and returns at a
  // falling edge. On acceptance the word is decoded and any event is queued.
  task automatic send_message(input logic [7:0] st, input logic [6:0] d1,
                              input logic [6:0] d2, output bit fired,
                              output synth_event_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    msg_if.valid       <= 1'b1;
    msg_if.status_byte <= st;
    msg_if.data1       <= d1;
    msg_if.data2       <= d2;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    fired = decode_message(st, d1, d2, ev);
    if (fired) pending_events.push_back(ev);
    words_sent++;
    if (st[7:4] inside {mcmd_pkg::ST_NOTEOFF, mcmd_pkg::ST_NOTEON, mcmd_pkg::ST_PRESSURE,
                        mcmd_pkg::ST_CONTROL, mcmd_pkg::ST_PROGRAM, mcmd_pkg::ST_PITCH})
      live_words++;
    @(negedge clk);
  endtask

  // Sender goes quiet until every queued event has come out.
  task automatic wait_for_events();
    msg_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    bit           fired;
    synth_event_t ev;
    logic [3:0]   chan;
    logic [6:0]   sel_hi;
    logic [6:0]   sel_lo;
    int           pick;

    foreach (sel_param_hi[i]) begin
      sel_param_hi[i] = mcmd_pkg::RPN_NONE;
      sel_param_lo[i] = mcmd_pkg::RPN_NONE;
    end
    rst_n              = 1'b0;
    msg_if.valid       = 1'b0;
    msg_if.status_byte = '0;
    msg_if.data1       = '0;
    msg_if.data2       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      send_message(directed_rows[i].st, directed_rows[i].d1, directed_rows[i].d2, fired, ev);
      if (directed_rows[i].known &&
          (fired != directed_rows[i].fires || (fired && ev != directed_rows[i].ev))) begin
        errors++;
        $display("%0t: directed row %0d: expected fires=%0b event=%h, got fires=%0b event=%h",
                 $time, i, directed_rows[i].fires, directed_rows[i].ev, fired, ev);
      end
    end
    wait_for_events();

    // random traffic, mostly well-formed
    while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
      chan = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // parameter select then data entry on one channel
        case ($urandom_range(0, 3))
          0: begin sel_hi = 7'h00; sel_lo = 7'h00; end
          1: begin sel_hi = 7'h7F; sel_lo = 7'h7F; end
          default: begin sel_hi = rand7(); sel_lo = rand7(); end
        endcase
        if ($urandom_range(0, 1)) begin
          send_message({mcmd_pkg::ST_CONTROL, chan}, mcmd_pkg::CC_RPN_LSB, sel_hi, fired, ev);
          send_message({mcmd_pkg::ST_CONTROL, chan}, mcmd_pkg::CC_RPN_MSB, sel_lo, fired, ev);
        end else begin
          send_message({mcmd_pkg::ST_CONTROL, chan}, mcmd_pkg::CC_RPN_MSB, sel_lo, fired, ev);
          send_message({mcmd_pkg::ST_CONTROL, chan}, mcmd_pkg::CC_RPN_LSB, sel_hi, fired, ev);
        end
        // traffic on a random channel between select and entry
        if ($urandom_range(0, 3) == 0)
          send_message({msg_types[$urandom_range(0, 5)], 4'($urandom_range(0, 15))},
                       rand7(), rand7(), fired, ev);
        // broken sequence: one half nulled before the entry
        if ($urandom_range(0, 5) == 0)
          send_message({mcmd_pkg::ST_CONTROL, chan},
                       $urandom_range(0, 1) ? mcmd_pkg::CC_NRPN_LSB : mcmd_pkg::CC_NRPN_MSB,
                       rand7(), fired, ev);
        repeat ($urandom_range(1, 3))
          send_message({mcmd_pkg::ST_CONTROL, chan}, mcmd_pkg::CC_DATA_ENTRY, rand7(),
                       fired, ev);
      end else if (pick < 40) begin
        // noise over the whole word
        send_message(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), fired, ev);
      end else begin
        pick = $urandom_range(0, 5);
        if (msg_types[pick] == mcmd_pkg::ST_CONTROL && $urandom_range(0, 4) != 0)
          send_message({mcmd_pkg::ST_CONTROL, chan}, known_ctls[$urandom_range(0, 14)],
                       rand7(), fired, ev);
        else
          send_message({msg_types[pick], chan}, rand7(), rand7(), fired, ev);
      end
      if ($urandom_range(0, 59) == 0) wait_for_events();
    end
    wait_for_events();

    $display("Sent %0d message words (%0d decodable); checked %0d events, %0d pitch range.",
             words_sent, live_words, events_checked, range_events);
    $display("Event kinds seen: %0d of 16; receiver long hold-offs: %0d.",
             $countones(kinds_seen), holdoffs);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: stretches of open, choppy and sparse ready, with an occasional
  // long hold-off so the pipe fills and backs up into the sender.
  initial begin : receiver
    rx_mode_t mode;
    int       phase;
    int       len;
    evt_if.ready = 1'b0;
    phase = 0;
    wait (rst_n === 1'b1);
    forever begin
      phase++;
      if (phase == 3 || $urandom_range(0, 11) == 0) begin
        mode = RX_HOLD;
        len  = $urandom_range(40, 80);
        holdoffs++;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 2));
        len  = $urandom_range(10, 60);
      end
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   evt_if.ready <= 1'b1;
          RX_CHOPPY: evt_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: evt_if.ready <= ($urandom_range(0, 3) == 0);
          default:   evt_if.ready <= 1'b0;
        endcase
      end
    end
  end

  // Event checker: every accepted event word against the oldest expectation.
  always @(posedge clk) begin : event_check
    synth_event_t got;
    synth_event_t want;
    if (rst_n && evt_if.valid && evt_if.ready) begin
      got.kind = mcmd_pkg::ev_kind_t'(evt_if.event_kind);
      got.chan = evt_if.channel_out;
      got.key  = evt_if.key_field;
      got.val  = evt_if.value_field;
      events_checked++;
      kinds_seen[got.kind] = 1'b1;
      if (got.kind == mcmd_pkg::EV_PITCHRANGE) range_events++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: event word with none expected: kind %0d ch %0d key %0d val %0d",
                   $time, got.kind, got.chan, got.key, got.val);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: event mismatch: expected kind %0d ch %0d key %0d val %0d",
                     $time, want.kind, want.chan, want.key, want.val,
                     ", got kind %0d ch %0d key %0d val %0d",
                     evt_if.event_kind, evt_if.channel_out, evt_if.key_field,
                     evt_if.value_field);
        end
      end
    end
  end

  // Watchdog on cycles where no word moves on either side.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((msg_if.valid && msg_if.ready) || (evt_if.valid && evt_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d events outstanding",
                 $time, stall_cycles, pending_events.size());
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
